// ----- rtl/core/ps2s1_pkg.sv -----
// Package with the scan code constants, the modifier and result types and the key map.
package ps2s1_pkg;

  localparam logic [7:0] CODE_PREFIX = 8'hE0;
  localparam logic [7:0] CODE_LSHIFT = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT = 8'h36;
  localparam logic [6:0] CODE_CTRL   = 7'h1D;
  localparam logic [6:0] CODE_ALT    = 7'h38;
  localparam logic [7:0] BREAK_BIT   = 8'h80;
  localparam logic [7:0] MAP_LEN     = 8'd79;

  typedef struct packed {
    logic alt_right;
    logic alt_left;
    logic ctrl_right;
    logic ctrl_left;
    logic shift_right;
    logic shift_left;
  } mod_flags_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    mod_flags_t mods;
  } result_t;

  // Set 1 key map, plain and shifted; codes past the end of the map give zero.
  function automatic logic [7:0] map_char(input logic [6:0] key, input logic shifted);
    logic [7:0] ch;
    ch = 8'h00;
    case (key)
      7'd2:  ch = shifted ? "!" : "1";
      7'd3:  ch = shifted ? "@" : "2";
      7'd4:  ch = shifted ? "#" : "3";
      7'd5:  ch = shifted ? "$" : "4";
      7'd6:  ch = shifted ? "%" : "5";
      7'd7:  ch = shifted ? "^" : "6";
      7'd8:  ch = shifted ? "&" : "7";
      7'd9:  ch = shifted ? "*" : "8";
      7'd10: ch = shifted ? "(" : "9";
      7'd11: ch = shifted ? ")" : "0";
      7'd12: ch = shifted ? "_" : "-";
      7'd13: ch = shifted ? "+" : "=";
      7'd14: ch = 8'h08;
      7'd15: ch = 8'h09;
      7'd16: ch = shifted ? "Q" : "q";
      7'd17: ch = shifted ? "W" : "w";
      7'd18: ch = shifted ? "E" : "e";
      7'd19: ch = shifted ? "R" : "r";
      7'd20: ch = shifted ? "T" : "t";
      7'd21: ch = shifted ? "Y" : "y";
      7'd22: ch = shifted ? "U" : "u";
      7'd23: ch = shifted ? "I" : "i";
      7'd24: ch = shifted ? "O" : "o";
      7'd25: ch = shifted ? "P" : "p";
      7'd26: ch = shifted ? "{" : "[";
      7'd27: ch = shifted ? "}" : "]";
      7'd28: ch = 8'h0A;
      7'd30: ch = shifted ? "A" : "a";
      7'd31: ch = shifted ? "S" : "s";
      7'd32: ch = shifted ? "D" : "d";
      7'd33: ch = shifted ? "F" : "f";
      7'd34: ch = shifted ? "G" : "g";
      7'd35: ch = shifted ? "H" : "h";
      7'd36: ch = shifted ? "J" : "j";
      7'd37: ch = shifted ? "K" : "k";
      7'd38: ch = shifted ? "L" : "l";
      7'd39: ch = shifted ? ":" : ";";
      7'd40: ch = shifted ? 8'h22 : 8'h27;
      7'd41: ch = shifted ? 8'h7E : 8'h60;
      7'd43: ch = shifted ? 8'h7C : 8'h5C;
      7'd44: ch = shifted ? "Z" : "z";
      7'd45: ch = shifted ? "X" : "x";
      7'd46: ch = shifted ? "C" : "c";
      7'd47: ch = shifted ? "V" : "v";
      7'd48: ch = shifted ? "B" : "b";
      7'd49: ch = shifted ? "N" : "n";
      7'd50: ch = shifted ? "M" : "m";
      7'd51: ch = shifted ? "<" : ",";
      7'd52: ch = shifted ? ">" : ".";
      7'd53: ch = shifted ? "?" : "/";
      7'd55: ch = "*";
      7'd57: ch = " ";
      7'd74: ch = "-";
      7'd78: ch = "+";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/core/ps2_set1_scancode_to_ascii.sv -----
// Top level of the set 1 scan code to ASCII decoder.
// Takes one scan code byte per cycle and gives one result word per byte: a character
// flag and code plus the six modifier flags as they stand after that byte. A byte is
// decoded straight out of the input register, and its result word goes into the result
// register when that is empty or being emptied. With out_ready held high a new byte is
// taken every cycle. While a result word waits, one more byte can still enter the input
// register; after that the input stalls until the waiting word is taken.
module ps2_set1_scancode_to_ascii
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_char_valid,
  output logic [6:0] out_char_code,
  output logic       out_shift_left,
  output logic       out_shift_right,
  output logic       out_ctrl_left,
  output logic       out_ctrl_right,
  output logic       out_alt_left,
  output logic       out_alt_right
);

  logic       adv;
  logic [7:0] cur_byte;
  result_t    res;
  result_t    out_res;

  ps2s1_scancode_top_stage u_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scan_byte (in_scan_byte),
    .res          (res),
    .adv          (adv),
    .cur_byte     (cur_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (out_res)
  );

  ps2s1_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .scan_byte (cur_byte),
    .res       (res)
  );

  assign out_char_valid  = out_res.char_valid;
  assign out_char_code   = out_res.char_code;
  assign out_shift_left  = out_res.mods.shift_left;
  assign out_shift_right = out_res.mods.shift_right;
  assign out_ctrl_left   = out_res.mods.ctrl_left;
  assign out_ctrl_right  = out_res.mods.ctrl_right;
  assign out_alt_left    = out_res.mods.alt_left;
  assign out_alt_right   = out_res.mods.alt_right;

endmodule

// ----- rtl/core/ps2s1_decode.sv -----
// Modifier and prefix state with the per-byte decode that produces the result word.
module ps2s1_decode
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] scan_byte,
  output result_t    res
);

  mod_flags_t mods_r, mods_nxt;
  logic       prefix_r, prefix_nxt;

  logic [6:0] key;
  logic       brk;
  logic [7:0] ch;

  always_comb begin
    key        = scan_byte[6:0];
    brk        = scan_byte[7];
    mods_nxt   = mods_r;
    prefix_nxt = prefix_r;
    ch         = 8'h00;
    // Shift codes come first so that a pending prefix survives them.
    if (scan_byte == CODE_LSHIFT || scan_byte == (CODE_LSHIFT | BREAK_BIT)) begin
      mods_nxt.shift_left = !brk;
    end else if (scan_byte == CODE_RSHIFT || scan_byte == (CODE_RSHIFT | BREAK_BIT)) begin
      mods_nxt.shift_right = !brk;
    end else if (scan_byte == CODE_PREFIX) begin
      prefix_nxt = 1'b1;
    end else if (prefix_r) begin
      if (key == CODE_CTRL) begin
        mods_nxt.ctrl_right = !brk;
      end else if (key == CODE_ALT) begin
        mods_nxt.alt_right = !brk;
      end
      prefix_nxt = 1'b0;
    end else if (key == CODE_CTRL) begin
      mods_nxt.ctrl_left = !brk;
    end else if (key == CODE_ALT) begin
      mods_nxt.alt_left = !brk;
    end else if (!brk && scan_byte < MAP_LEN) begin
      ch = map_char(key, mods_r.shift_left | mods_r.shift_right);
    end
    res.char_valid = (ch != 8'h00);
    res.char_code  = ch[6:0];
    res.mods       = mods_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r   <= '0;
      prefix_r <= 1'b0;
    end else if (en) begin
      mods_r   <= mods_nxt;
      prefix_r <= prefix_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(mods_r) && $stable(prefix_r))
    else $error("decode state changed without an accepted byte");

  a_prefix_arms: assert property (@(posedge clk) disable iff (!rst_n)
    en && scan_byte == CODE_PREFIX |=> prefix_r && $stable(mods_r))
    else $error("prefix byte did not arm the prefix");

  a_char_only_unprefixed_make: assert property (@(posedge clk) disable iff (!rst_n)
    res.char_valid |-> !prefix_r && !brk && mods_nxt == mods_r)
    else $error("character produced for a prefixed, break or modifier byte");
`endif

endmodule

// ----- rtl/core/ps2s1_scancode_top_stage.sv -----
// Input byte register and result register with the valid/ready flow control between them.
module ps2s1_scancode_top_stage
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  input  result_t    res,
  output logic       adv,
  output logic [7:0] cur_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       out_vld_r;
  result_t    out_res_r;

  // A byte moves into the result register when that register is empty or being emptied.
  assign adv       = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || adv;
  assign cur_byte  = s1_byte_r;
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_scan_byte;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

endmodule

// ----- test/scan_decode_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts each decoded word from the accepted scan bytes and compares it.
module scan_decode_checker
  import ps2s1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_scan_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_char_valid,
  input  logic [6:0]  out_char_code,
  input  logic        out_shift_left,
  input  logic        out_shift_right,
  input  logic        out_ctrl_left,
  input  logic        out_ctrl_right,
  input  logic        out_alt_left,
  input  logic        out_alt_right,
  output int unsigned fail_count,
  output int unsigned words_pending
);

  localparam int unsigned KEY_COUNT = 79;

  // Byte k of each map is the character for make code k; the first byte is code zero.
  localparam logic [KEY_COUNT*8-1:0] PLAIN_KEYS = {
    8'h00, 8'h00, "1234567890-=", 8'h08, 8'h09, "qwertyuiop[]", 8'h0A, 8'h00,
    "asdfghjkl;", 8'h27, 8'h60, 8'h00, 8'h5C, "zxcvbnm,./", 8'h00, "*", 8'h00, " ",
    {16{8'h00}}, "-", {3{8'h00}}, "+"
  };
  localparam logic [KEY_COUNT*8-1:0] SHIFTED_KEYS = {
    8'h00, 8'h00, "!@#$%^&*()_+", 8'h08, 8'h09, "QWERTYUIOP{}", 8'h0A, 8'h00,
    "ASDFGHJKL:", 8'h22, 8'h7E, 8'h00, 8'h7C, "ZXCVBNM<>?", 8'h00, "*", 8'h00, " ",
    {16{8'h00}}, "-", {3{8'h00}}, "+"
  };

  mod_flags_t held_mods;
  logic       e0_seen;
  result_t    expected_words[$];

  function automatic logic [6:0] key_char(input logic [7:0] code, input logic shifted);
    logic [7:0] ch;
    int unsigned pos;
    ch = 8'h00;
    if (code < MAP_LEN) begin
      pos = (KEY_COUNT - 1 - int'(code)) * 8;
      ch = shifted ? SHIFTED_KEYS[pos +: 8] : PLAIN_KEYS[pos +: 8];
    end
    return ch[6:0];
  endfunction

  // Shift codes are handled ahead of the prefix, so a pending prefix survives them.
  task automatic decode_scan(input logic [7:0] code);
    result_t    w;
    logic       brk;
    logic [6:0] key;
    brk = code[7];
    key = code[6:0];
    w = '0;
    if (key == CODE_LSHIFT[6:0]) begin
      held_mods.shift_left = !brk;
    end else if (key == CODE_RSHIFT[6:0]) begin
      held_mods.shift_right = !brk;
    end else if (code == CODE_PREFIX) begin
      e0_seen = 1'b1;
    end else if (e0_seen) begin
      if (key == CODE_CTRL) begin
        held_mods.ctrl_right = !brk;
      end else if (key == CODE_ALT) begin
        held_mods.alt_right = !brk;
      end
      e0_seen = 1'b0;
    end else if (key == CODE_CTRL) begin
      held_mods.ctrl_left = !brk;
    end else if (key == CODE_ALT) begin
      held_mods.alt_left = !brk;
    end else if (!brk) begin
      w.char_code = key_char(code, held_mods.shift_left | held_mods.shift_right);
    end
    w.char_valid = (w.char_code != 7'd0);
    w.mods = held_mods;
    expected_words.push_back(w);
  endtask

  task automatic compare_bit(input string field, input logic exp, input logic got);
    if (exp !== got) begin
      $error("%s: expected %0h, got %0h", field, exp, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t w;
    if (!rst_n) begin
      held_mods = '0;
      e0_seen = 1'b0;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_scan(in_scan_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no scan byte waiting for it");
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          compare_bit("char_valid", w.char_valid, out_char_valid);
          if (w.char_code !== out_char_code) begin
            $error("char_code: expected %0h, got %0h", w.char_code, out_char_code);
            fail_count++;
          end
          compare_bit("shift_left", w.mods.shift_left, out_shift_left);
          compare_bit("shift_right", w.mods.shift_right, out_shift_right);
          compare_bit("ctrl_left", w.mods.ctrl_left, out_ctrl_left);
          compare_bit("ctrl_right", w.mods.ctrl_right, out_ctrl_right);
          compare_bit("alt_left", w.mods.alt_left, out_alt_left);
          compare_bit("alt_right", w.mods.alt_right, out_alt_right);
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, scan byte stimulus, result back-pressure and verdict.
module testbench
  import ps2s1_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SQUEEZE_CYCLES = 60;
  localparam int unsigned PHASE_BYTES    = 150;
  localparam int unsigned OPENING_COUNT  = 26;

  localparam logic [7:0] CTRL_MAKE  = {1'b0, CODE_CTRL};
  localparam logic [7:0] CTRL_BREAK = {1'b1, CODE_CTRL};
  localparam logic [7:0] ALT_MAKE   = {1'b0, CODE_ALT};
  localparam logic [7:0] ALT_BREAK  = {1'b1, CODE_ALT};

  localparam logic [OPENING_COUNT*8-1:0] OPENING_BYTES = {
    8'h00, 8'hFF, 8'h02, CODE_LSHIFT, 8'h1E, CODE_RSHIFT, 8'h10,
    BREAK_BIT | CODE_LSHIFT, BREAK_BIT | CODE_RSHIFT,
    CODE_PREFIX, CODE_PREFIX, CTRL_MAKE, CODE_PREFIX, ALT_MAKE, CTRL_MAKE, ALT_MAKE,
    CODE_PREFIX, 8'h48, CODE_PREFIX, CODE_LSHIFT, CTRL_BREAK, BREAK_BIT | CODE_LSHIFT,
    8'h9E, 8'h4F, 8'h7F, 8'h4E
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready, out_valid, out_char_valid;
  logic [6:0] out_char_code;
  logic       out_shift_left, out_shift_right, out_ctrl_left, out_ctrl_right;
  logic       out_alt_left, out_alt_right;

  int unsigned fail_count, words_pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_left = 0;
  bit          squeeze_req = 1'b0;
  bit          squeezed = 1'b0;

  ps2_set1_scancode_to_ascii uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_scan_byte   (in_scan_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_valid (out_char_valid),
    .out_char_code  (out_char_code),
    .out_shift_left (out_shift_left),
    .out_shift_right(out_shift_right),
    .out_ctrl_left  (out_ctrl_left),
    .out_ctrl_right (out_ctrl_right),
    .out_alt_left   (out_alt_left),
    .out_alt_right  (out_alt_right)
  );

  scan_decode_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_scan_byte   (in_scan_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_valid (out_char_valid),
    .out_char_code  (out_char_code),
    .out_shift_left (out_shift_left),
    .out_shift_right(out_shift_right),
    .out_ctrl_left  (out_ctrl_left),
    .out_ctrl_right (out_ctrl_right),
    .out_alt_left   (out_alt_left),
    .out_alt_right  (out_alt_right),
    .fail_count     (fail_count),
    .words_pending  (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One long hold-off on request lets the block fill up and push back on its input.
  always @(posedge clk) begin
    if (squeeze_req && !squeezed) begin
      squeezed <= 1'b1;
      hold_left <= SQUEEZE_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Returns in the time step of the edge that accepted the byte.
  task automatic send_byte(input logic [7:0] code);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_scan_byte <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_shift_code();
    case ($urandom_range(3))
      0: return CODE_LSHIFT;
      1: return CODE_RSHIFT;
      2: return BREAK_BIT | CODE_LSHIFT;
      default: return BREAK_BIT | CODE_RSHIFT;
    endcase
  endfunction

  function automatic logic [7:0] pick_ctrl_alt_code();
    case ($urandom_range(3))
      0: return CTRL_MAKE;
      1: return CTRL_BREAK;
      2: return ALT_MAKE;
      default: return ALT_BREAK;
    endcase
  endfunction

  // Mostly typing-like traffic with held modifiers and prefixed keys, plus raw noise.
  task automatic send_random_burst();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_byte(8'($urandom_range(8'h58)));
    end else if (pick < 40) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 52) begin
      send_byte(pick_shift_code());
    end else if (pick < 64) begin
      send_byte(pick_ctrl_alt_code());
    end else if (pick < 82) begin
      send_byte(CODE_PREFIX);
      case ($urandom_range(3))
        0: send_byte(8'($urandom_range(255)));
        1: send_byte(pick_shift_code());
        default: send_byte(pick_ctrl_alt_code());
      endcase
    end else begin
      send_byte(BREAK_BIT | 8'($urandom_range(8'h58)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < OPENING_COUNT; i++) begin
      send_byte(OPENING_BYTES[(OPENING_COUNT - 1 - i) * 8 +: 8]);
    end
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  squeeze_req = 1'b1; end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      while (bytes_sent < OPENING_COUNT + PHASE_BYTES * (ph + 1)) send_random_burst();
    end
    in_valid <= 1'b0;
    stall_pct = 0;
    while (words_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
